FILE: hdl/zbdt_pkg.sv
// ----------------------------------------------------------------------------
// zbdt_pkg
// Shared types and constants of the depth-test block with coverage statistics.
// ----------------------------------------------------------------------------
package zbdt_pkg;

  // Image size and the depth store that follows from it.
  localparam int IMG_WIDTH  = 64;
  localparam int IMG_HEIGHT = 64;
  localparam int PIXELS     = IMG_WIDTH * IMG_HEIGHT;
  localparam int PIX_W      = $clog2(PIXELS);

  // Field widths of the words on the two channels.
  localparam int COORD_W = 6;
  localparam int DEPTH_W = 16;
  localparam int SUM_W   = 28;
  localparam int COUNT_W = 13;

  // Reset values of the running statistics.
  localparam logic [COORD_W-1:0] BOX_MIN_RST = COORD_W'(63);
  localparam logic [COORD_W-1:0] BOX_MAX_RST = '0;
  localparam logic [DEPTH_W-1:0] NEAR_RST    = '1;

  // A stored depth of zero marks an empty pixel.
  localparam logic [DEPTH_W-1:0] DEPTH_EMPTY = '0;

  // One fragment word.
  typedef struct packed {
    logic [COORD_W-1:0] pix_x;
    logic [COORD_W-1:0] pix_y;
    logic [DEPTH_W-1:0] frag_depth;
  } frag_t;

  // One statistics word.
  typedef struct packed {
    logic [COORD_W-1:0] box_min_x;
    logic [COORD_W-1:0] box_min_y;
    logic [COORD_W-1:0] box_max_x;
    logic [COORD_W-1:0] box_max_y;
    logic [SUM_W-1:0]   depth_sum;
    logic [DEPTH_W-1:0] nearest_depth;
    logic [COUNT_W-1:0] covered_count;
    logic               depth_written;
  } stat_t;

  // Write request from the depth-test logic to the depth store.
  typedef struct packed {
    logic               en;
    logic [PIX_W-1:0]   addr;
    logic [DEPTH_W-1:0] data;
  } store_wr_t;

endpackage

FILE: hdl/zbdt_if.sv
// ----------------------------------------------------------------------------
// zbdt_frag_if / zbdt_stat_if
// Valid/ready channels that carry fragment words and statistics words.
// ----------------------------------------------------------------------------
interface zbdt_frag_if;
  import zbdt_pkg::*;

  logic  valid;
  logic  ready;
  frag_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface zbdt_stat_if;
  import zbdt_pkg::*;

  logic  valid;
  logic  ready;
  stat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/zbdt_store.sv
// ----------------------------------------------------------------------------
// zbdt_store
// Depth store: one synchronous memory with a registered read, a clearing pass
// after reset and forwarding of a write that lands on the entry being read.
// ----------------------------------------------------------------------------
module zbdt_store
  import zbdt_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               rd_en,
  input  logic [PIX_W-1:0]   rd_addr,
  input  store_wr_t          wr,
  output logic [DEPTH_W-1:0] rd_depth,
  output logic               clear_busy
);

  logic [DEPTH_W-1:0] mem [PIXELS];

  logic [PIX_W:0]     clr_cnt_r;
  logic [PIX_W:0]     clr_cnt_nxt;
  logic [DEPTH_W-1:0] rdata_r;
  logic               fwd_hit_r;
  logic [DEPTH_W-1:0] fwd_data_r;
  logic               mem_we;
  logic [PIX_W-1:0]   mem_waddr;
  logic [DEPTH_W-1:0] mem_wdata;

  // The clearing pass runs until the counter reaches the store depth.
  assign clear_busy  = (clr_cnt_r < (PIX_W+1)'(PIXELS));
  assign clr_cnt_nxt = clear_busy ? clr_cnt_r + 1'b1 : clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else begin
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  // The single write port serves the clearing pass first, then the depth test.
  always_comb begin
    if (clear_busy) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_r[PIX_W-1:0];
      mem_wdata = DEPTH_EMPTY;
    end else begin
      mem_we    = wr.en;
      mem_waddr = wr.addr;
      mem_wdata = wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  // Registered read; a write to the same entry in the same cycle is forwarded.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r    <= mem[rd_addr];
      fwd_hit_r  <= wr.en && (wr.addr == rd_addr);
      fwd_data_r <= wr.data;
    end
  end

  assign rd_depth = fwd_hit_r ? fwd_data_r : rdata_r;

endmodule

FILE: hdl/zbuffer_depth_test_with_stats.sv
// ----------------------------------------------------------------------------
// zbuffer_depth_test_with_stats
// Depth test on a 64 x 64 depth store with running coverage statistics.
// ----------------------------------------------------------------------------
// After reset the block clears the depth store, one entry a cycle, and
// holds in_frag.ready low meanwhile. From then on it takes one fragment word
// per cycle while out_stat is not stalled: the store is read in the cycle the
// fragment is accepted, and once the output register is free the depth test,
// the write-back and the statistics update happen together, so each
// fragment's statistics word is loaded into the output register from the
// fragment stage register. A write-back that hits the entry read for the
// following fragment is forwarded, so back-to-back fragments on the same
// pixel see each other's result. Each fragment yields exactly one statistics
// word.
// ----------------------------------------------------------------------------
module zbuffer_depth_test_with_stats
  import zbdt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  zbdt_frag_if.sink   in_frag,
  zbdt_stat_if.source out_stat
);

  logic               in_acc;
  logic               s1_adv;
  logic               clear_busy;
  logic [DEPTH_W-1:0] stored_depth;
  logic [PIX_W-1:0]   rd_addr;
  store_wr_t          wr;

  logic               s1_valid_r;
  frag_t              s1_frag_r;
  logic               out_valid_r;
  stat_t              out_data_r;

  logic [COORD_W-1:0] min_col_r, min_col_nxt;
  logic [COORD_W-1:0] min_row_r, min_row_nxt;
  logic [COORD_W-1:0] max_col_r, max_col_nxt;
  logic [COORD_W-1:0] max_row_r, max_row_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [DEPTH_W-1:0] near_r, near_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;

  logic               in_img;
  logic               hit;
  logic               empty;
  logic               nearer;
  logic               written;

  // Handshake: the fragment stage moves on when the output register is free.
  assign s1_adv        = s1_valid_r && (!out_valid_r || out_stat.ready);
  assign in_frag.ready = !clear_busy && (!s1_valid_r || s1_adv);
  assign in_acc        = in_frag.valid && in_frag.ready;

  assign rd_addr = PIX_W'(32'(in_frag.data.pix_y) * 32'(IMG_WIDTH)
                          + 32'(in_frag.data.pix_x));

  zbdt_store u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_en      (in_acc),
    .rd_addr    (rd_addr),
    .wr         (wr),
    .rd_depth   (stored_depth),
    .clear_busy (clear_busy)
  );

  // Depth test against the stored value.
  always_comb begin
    in_img  = (32'(s1_frag_r.pix_x) < 32'(IMG_WIDTH))
           && (32'(s1_frag_r.pix_y) < 32'(IMG_HEIGHT));
    hit     = (s1_frag_r.frag_depth != DEPTH_EMPTY) && in_img;
    empty   = (stored_depth == DEPTH_EMPTY);
    nearer  = (stored_depth > s1_frag_r.frag_depth);
    written = hit && (empty || nearer);

    wr.en   = s1_adv && written;
    wr.addr = PIX_W'(32'(s1_frag_r.pix_y) * 32'(IMG_WIDTH) + 32'(s1_frag_r.pix_x));
    wr.data = s1_frag_r.frag_depth;
  end

  // Statistics after this fragment.
  always_comb begin
    min_col_nxt = (s1_frag_r.pix_x < min_col_r) ? s1_frag_r.pix_x : min_col_r;
    min_row_nxt = (s1_frag_r.pix_y < min_row_r) ? s1_frag_r.pix_y : min_row_r;
    max_col_nxt = (s1_frag_r.pix_x > max_col_r) ? s1_frag_r.pix_x : max_col_r;
    max_row_nxt = (s1_frag_r.pix_y > max_row_r) ? s1_frag_r.pix_y : max_row_r;
    near_nxt    = (s1_frag_r.frag_depth < near_r) ? s1_frag_r.frag_depth : near_r;
    sum_nxt     = sum_r;
    count_nxt   = count_r;
    if (written) begin
      if (empty) begin
        sum_nxt   = sum_r + SUM_W'(s1_frag_r.frag_depth);
        count_nxt = count_r + 1'b1;
      end else begin
        sum_nxt   = sum_r - SUM_W'(stored_depth) + SUM_W'(s1_frag_r.frag_depth);
      end
    end
  end

  // Fragment stage register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_frag_r <= in_frag.data;
    end
  end

  // Running statistics.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_col_r <= BOX_MIN_RST;
      min_row_r <= BOX_MIN_RST;
      max_col_r <= BOX_MAX_RST;
      max_row_r <= BOX_MAX_RST;
      sum_r     <= '0;
      near_r    <= NEAR_RST;
      count_r   <= '0;
    end else if (s1_adv) begin
      min_col_r <= min_col_nxt;
      min_row_r <= min_row_nxt;
      max_col_r <= max_col_nxt;
      max_row_r <= max_row_nxt;
      sum_r     <= sum_nxt;
      near_r    <= near_nxt;
      count_r   <= count_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_stat.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r.box_min_x     <= min_col_nxt;
      out_data_r.box_min_y     <= min_row_nxt;
      out_data_r.box_max_x     <= max_col_nxt;
      out_data_r.box_max_y     <= max_row_nxt;
      out_data_r.depth_sum     <= sum_nxt;
      out_data_r.nearest_depth <= near_nxt;
      out_data_r.covered_count <= count_nxt;
      out_data_r.depth_written <= written;
    end
  end

  assign out_stat.valid = out_valid_r;
  assign out_stat.data  = out_data_r;

endmodule

FILE: hdl/zbdt_checker.sv
// ----------------------------------------------------------------------------
// zbdt_checker
// Port-level checks of the depth-test block, bound to the top level.
// ----------------------------------------------------------------------------
module zbdt_checker
  import zbdt_pkg::*;
(
  input logic  clk,
  input logic  rst_n,
  input logic  out_valid,
  input logic  out_ready,
  input stat_t out_data
);

  // A stalled statistics word stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("statistics word changed while stalled");

  // No word leaves right after reset.
  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // Every word follows at least one fragment, so the box is never inverted.
  a_box_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.box_min_x <= out_data.box_max_x)
               && (out_data.box_min_y <= out_data.box_max_y))
    else $error("bounding box inverted");

  // A stored fragment means at least one pixel is covered.
  a_written_cov: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.depth_written |-> out_data.covered_count != '0)
    else $error("fragment stored but no pixel covered");

endmodule

bind zbuffer_depth_test_with_stats zbdt_checker u_zbdt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_stat.valid),
  .out_ready (out_stat.ready),
  .out_data  (out_stat.data)
);
